// ===== hw/rtl/polynomial_integrator_defines.svh =====
// Assertion macros shared by the polynomial integrator RTL.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef POLYNOMIAL_INTEGRATOR_DEFINES_SVH
`define POLYNOMIAL_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PINT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PINT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pint_pkg.sv =====
// Package for the polynomial integrator: types, constants and saturating helpers.
// No dependencies; imported by every module of the block except pint_div.
`timescale 1ns / 1ps

package pint_pkg;

    localparam int DATA_W    = 64;
    localparam int DIFF_W    = 49;
    localparam int CFG_IDX_W = 3;
    localparam int POLY_DEG  = 4;

    typedef logic signed [DATA_W-1:0] q32_t;

    localparam q32_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q32_t Q_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_X4       = 3'd0,
        REG_COEFF_X3       = 3'd1,
        REG_COEFF_X2       = 3'd2,
        REG_COEFF_X1       = 3'd3,
        REG_COEFF_X0       = 3'd4,
        REG_INTERVAL_COUNT = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PK_NODE,
        PK_MID,
        PK_PA,
        PK_PB
    } pt_kind_t;

    typedef struct packed {
        logic sat;
        q32_t val;
    } sres_t;

    typedef struct packed {
        logic     valid;
        logic     last;
        pt_kind_t kind;
        q32_t     x;
        q32_t     acc;
        logic     sat;
    } pt_beat_t;

    function automatic q32_t widen_q16(logic [31:0] v);
        return {{16{v[31]}}, v, 16'h0000};
    endfunction

    function automatic sres_t sadd(q32_t a, q32_t b);
        sres_t r;
        q32_t  s;
        s     = a + b;
        r.sat = 1'b0;
        r.val = s;
        if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
        begin
            r.sat = 1'b1;
            r.val = a[DATA_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic sres_t ssub(q32_t a, q32_t b);
        sres_t r;
        q32_t  s;
        s     = a - b;
        r.sat = 1'b0;
        r.val = s;
        if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
        begin
            r.sat = 1'b1;
            r.val = a[DATA_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    // Division by two rounding toward zero.
    function automatic q32_t half_tz(q32_t a);
        q32_t t;
        t = a + {{(DATA_W-1){1'b0}}, a[DATA_W-1]};
        return t >>> 1;
    endfunction

    function automatic sres_t dbl_sat(q32_t a);
        sres_t r;
        r.sat = (a[DATA_W-1] != a[DATA_W-2]);
        r.val = {a[DATA_W-2:0], 1'b0};
        if (r.sat)
        begin
            r.val = a[DATA_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic sres_t quad_sat(q32_t a);
        sres_t r;
        r.sat = !((a[DATA_W-1:DATA_W-3] == 3'b000) || (a[DATA_W-1:DATA_W-3] == 3'b111));
        r.val = {a[DATA_W-3:0], 2'b00};
        if (r.sat)
        begin
            r.val = a[DATA_W-1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pint_qmul.sv =====
// Two-stage saturating Q32.32 multiplier built from four 32x32 partial products.
// Depends on pint_pkg.
`timescale 1ns / 1ps

module pint_qmul
    import pint_pkg::*;
(
    input  logic clk,
    input  q32_t a,
    input  q32_t b,
    output q32_t prod,
    output logic prod_sat
);

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic         neg_reg;
    logic [127:0] full;
    logic [63:0]  mag;
    logic         over;
    q32_t         prod_next;
    logic         sat_next;
    q32_t         prod_reg;
    logic         sat_reg;

    always_comb
    begin
        ua = a[63] ? (~a + 64'd1) : a;
        ub = b[63] ? (~b + 64'd1) : b;
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= ua[31:0] * ub[31:0];
        p01_reg <= ua[31:0] * ub[63:32];
        p10_reg <= ua[63:32] * ub[31:0];
        p11_reg <= ua[63:32] * ub[63:32];
        neg_reg <= a[63] ^ b[63];
    end

    always_comb
    begin
        full = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0}
             + {32'd0, p10_reg, 32'd0} + {64'd0, p00_reg};
        mag  = full[95:32];
        over = |full[127:96];
        sat_next  = 1'b0;
        prod_next = mag;
        if (neg_reg)
        begin
            if (over || (mag[63] && (|mag[62:0])))
            begin
                sat_next  = 1'b1;
                prod_next = Q_MIN;
            end
            else
            begin
                prod_next = ~mag + 64'd1;
            end
        end
        else if (over || mag[63])
        begin
            sat_next  = 1'b1;
            prod_next = Q_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sat_reg  <= sat_next;
    end

    assign prod     = prod_reg;
    assign prod_sat = sat_reg;

endmodule

// ===== hw/rtl/pint_cell.sv =====
// One Horner cell: acc * x + coeff with saturation, three pipeline stages.
// Depends on pint_pkg and pint_qmul.
`timescale 1ns / 1ps

module pint_cell
    import pint_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pt_beat_t beat_in,
    input  q32_t     coeff,
    output pt_beat_t beat_out
);

    q32_t     prod;
    logic     prod_sat;
    logic     v1_reg;
    logic     v2_reg;
    logic     vout_reg;
    pt_beat_t side1_reg;
    pt_beat_t side2_reg;
    pt_beat_t out_reg;
    pt_beat_t out_next;
    sres_t    acc_add;

    pint_qmul u_mul
    (
        .clk      (clk),
        .a        (beat_in.acc),
        .b        (beat_in.x),
        .prod     (prod),
        .prod_sat (prod_sat)
    );

    assign acc_add = sadd(prod, coeff);

    always_comb
    begin
        out_next     = side2_reg;
        out_next.acc = acc_add.val;
        out_next.sat = side2_reg.sat | prod_sat | acc_add.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= beat_in.valid;
            v2_reg   <= v1_reg;
            vout_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= beat_in;
        side2_reg <= side1_reg;
        out_reg   <= out_next;
    end

    always_comb
    begin
        beat_out       = out_reg;
        beat_out.valid = vout_reg;
    end

endmodule

// ===== hw/rtl/pint_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module pint_div
#(
    parameter int DEND_W = 49,
    parameter int DSOR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEND_W-1:0] dividend,
    input  logic [DSOR_W-1:0] divisor,
    output logic              done,
    output logic [DEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DEND_W + 1);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t         state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DEND_W-1:0] q_reg;
    logic [DSOR_W:0]   rem_reg;
    logic [DSOR_W-1:0] dsor_reg;
    logic [DSOR_W:0]   rem_sh;
    logic              ge;
    logic [DSOR_W:0]   rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg[DSOR_W-1:0], q_reg[DEND_W-1]};
        ge       = (rem_sh >= {1'b0, dsor_reg});
        rem_next = ge ? (rem_sh - {1'b0, dsor_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DV_RUN;
                        cnt_reg   <= CNT_W'(DEND_W);
                    end
                end
                DV_RUN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= DV_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (state_reg == DV_RUN)
        begin
            q_reg   <= {q_reg[DEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hw/rtl/polynomial_integrator.sv =====
// Top level of the polynomial integrator: sequencer, point generator, Horner cell chain
// and result accumulation. Depends on pint_pkg, pint_cell, pint_qmul, pint_div and
// polynomial_integrator_defines.svh.
//
// Usage: write the five Q16.16 coefficients and the step count through the config
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block is idle; cfg_ready
// is always high. An integration starts at a clock edge where start is high and busy
// is low; command selects trapezoid (0) or Simpson (1), and lower_bound/upper_bound
// give the range in Q16.16. busy stays high until the result beat.
// The result beat is one cycle of done with integral (Q32.32) and saturated; the
// receiver cannot hold it off, and busy drops in the same cycle.
// The step size takes one division (two for Simpson, where a second division of the
// range by 6n gives h/6). Points then enter the four-cell Horner chain at one point per
// cycle for trapezoid (n+1 points); for Simpson, states ST_GEN_S0 to ST_GEN_S2 send a
// midpoint and a node per loop (2n+1 points in all). Chain results then pass through
// the final multiplier before the result beat. One item is in flight.
// Reset restores the coefficients to zero and the step count to ten, and aborts
// any run in progress without a result.
`timescale 1ns / 1ps
`include "polynomial_integrator_defines.svh"

module polynomial_integrator
    import pint_pkg::*;
#(
    parameter int INTERVAL_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 command,
    input  logic signed [31:0]   lower_bound,
    input  logic signed [31:0]   upper_bound,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic signed [63:0]   integral,
    output logic                 saturated
);

    localparam int PW = DATA_W + INTERVAL_BITS + 1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_H_GO,
        ST_DIV_H_WAIT,
        ST_DIV_6_GO,
        ST_DIV_6_WAIT,
        ST_GEN_T,
        ST_GEN_S0,
        ST_GEN_S1,
        ST_GEN_S2,
        ST_TAIL0,
        ST_TAIL1,
        ST_TAIL2,
        ST_DRAIN,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_MUL_GO,
        ST_MUL_WAIT
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic                      done_reg;

    logic [31:0]               coeff_reg [0:POLY_DEG];
    logic [15:0]               icount_reg;

    logic                      cmd_reg;
    q32_t                      a_reg;
    q32_t                      b_reg;
    logic [INTERVAL_BITS-1:0]  n_reg;
    q32_t                      h_reg;
    q32_t                      hh_reg;
    q32_t                      h6_reg;
    logic signed [PW-1:0]      p_reg;
    logic [INTERVAL_BITS-1:0]  i_reg;
    q32_t                      xh_reg;
    logic                      xh_sat_reg;

    logic                      pt_valid_reg;
    logic                      pt_last_reg;
    pt_kind_t                  pt_kind_reg;
    q32_t                      pt_x_reg;
    logic                      pt_sat_reg;

    logic                      have_prev_reg;
    q32_t                      prev_reg;
    q32_t                      mids_reg;
    q32_t                      nodes_reg;
    q32_t                      pa_reg;
    q32_t                      pb_reg;
    q32_t                      total_reg;
    q32_t                      sum_reg;
    logic                      sat_acc_reg;

    logic                      mq_valid_reg;
    logic                      mq_last_reg;
    q32_t                      mq_a_reg;
    q32_t                      mq_b_reg;
    logic                      mv1_reg;
    logic                      mv2_reg;
    logic                      ml1_reg;
    logic                      ml2_reg;
    q32_t                      integral_reg;
    logic                      saturated_reg;

    pt_beat_t                  chain [0:POLY_DEG];
    q32_t                      coeff_w [0:POLY_DEG];
    pt_beat_t                  co;

    logic [31:0]               ic_ext;
    logic [31:0]               cap32;
    logic [31:0]               n32;
    q32_t                      diff;
    logic [DATA_W-1:0]         diff_mag;
    logic [INTERVAL_BITS+2:0]  n6;
    logic                      div_start;
    logic [DIFF_W-1:0]         div_dend;
    logic [INTERVAL_BITS+2:0]  div_dsor;
    logic                      div_done;
    logic [DIFF_W-1:0]         div_quot;
    q32_t                      quot_ext;

    q32_t                      p_clip;
    logic                      p_clip_sat;
    sres_t                     x_add;
    sres_t                     mid_sub;
    sres_t                     bmid_sub;
    sres_t                     avg_add;
    sres_t                     mids_add;
    sres_t                     nodes_add;
    sres_t                     fin1_add;
    sres_t                     nodes2;
    sres_t                     fin2_add;
    sres_t                     mids4;
    sres_t                     fin3_add;
    sres_t                     sum_add;
    q32_t                      mul_prod;
    logic                      mul_sat;
    logic                      sat_new;
    logic                      mul_final;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign integral  = integral_reg;
    assign saturated = saturated_reg;

    // Step count: zero counts as one, large values are capped.
    always_comb
    begin
        ic_ext = {16'd0, icount_reg};
        cap32  = (32'd1 << INTERVAL_BITS) - 32'd1;
        if (icount_reg == 16'd0)
        begin
            n32 = 32'd1;
        end
        else if (ic_ext > cap32)
        begin
            n32 = cap32;
        end
        else
        begin
            n32 = ic_ext;
        end
    end

    // The h/6 step divides the range by 6n, which equals dividing the truncated h by 6.
    always_comb
    begin
        diff      = b_reg - a_reg;
        diff_mag  = diff[DATA_W-1] ? (~diff + 64'd1) : diff;
        n6        = {1'b0, n_reg, 2'b00} + {2'b00, n_reg, 1'b0};
        div_start = (state_reg == ST_DIV_H_GO) || (state_reg == ST_DIV_6_GO);
        div_dend  = diff_mag[DIFF_W-1:0];
        div_dsor  = (state_reg == ST_DIV_H_GO) ? {3'b000, n_reg} : n6;
        quot_ext  = {{(DATA_W-DIFF_W){1'b0}}, div_quot};
    end

    pint_div
    #(
        .DEND_W (DIFF_W),
        .DSOR_W (INTERVAL_BITS + 3)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dend),
        .divisor  (div_dsor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        if ((&p_reg[PW-1:DATA_W-1]) || !(|p_reg[PW-1:DATA_W-1]))
        begin
            p_clip     = p_reg[DATA_W-1:0];
            p_clip_sat = 1'b0;
        end
        else
        begin
            p_clip     = p_reg[PW-1] ? Q_MIN : Q_MAX;
            p_clip_sat = 1'b1;
        end
        x_add    = sadd(a_reg, p_clip);
        mid_sub  = ssub(xh_reg, hh_reg);
        bmid_sub = ssub(b_reg, hh_reg);
    end

    always_comb
    begin
        for (int k = 0; k <= POLY_DEG; k++)
        begin
            coeff_w[k] = widen_q16(coeff_reg[k]);
        end
        chain[0].valid = pt_valid_reg;
        chain[0].last  = pt_last_reg;
        chain[0].kind  = pt_kind_reg;
        chain[0].x     = pt_x_reg;
        chain[0].acc   = coeff_w[0];
        chain[0].sat   = pt_sat_reg;
    end

    for (genvar k = 0; k < POLY_DEG; k++)
    begin : g_cell
        pint_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain[k]),
            .coeff    (coeff_w[k+1]),
            .beat_out (chain[k+1])
        );
    end

    assign co = chain[POLY_DEG];

    pint_qmul u_mul
    (
        .clk      (clk),
        .a        (mq_a_reg),
        .b        (mq_b_reg),
        .prod     (mul_prod),
        .prod_sat (mul_sat)
    );

    always_comb
    begin
        avg_add   = sadd(prev_reg, co.acc);
        mids_add  = sadd(mids_reg, co.acc);
        nodes_add = sadd(nodes_reg, co.acc);
        fin1_add  = sadd(pa_reg, pb_reg);
        nodes2    = dbl_sat(nodes_reg);
        fin2_add  = sadd(total_reg, nodes2.val);
        mids4     = quad_sat(mids_reg);
        fin3_add  = sadd(total_reg, mids4.val);
        sum_add   = sadd(sum_reg, mul_prod);
        mul_final = (state_reg == ST_MUL_WAIT) && mv2_reg && ml2_reg;
        sat_new   = (co.valid && co.sat)
                  | (co.valid && !cmd_reg && have_prev_reg && avg_add.sat)
                  | (co.valid && cmd_reg && (co.kind == PK_MID) && mids_add.sat)
                  | (co.valid && cmd_reg && (co.kind == PK_NODE) && nodes_add.sat)
                  | ((state_reg == ST_FIN1) && fin1_add.sat)
                  | ((state_reg == ST_FIN2) && (nodes2.sat || fin2_add.sat))
                  | ((state_reg == ST_FIN3) && (mids4.sat || fin3_add.sat))
                  | (mv2_reg && mul_sat)
                  | (mv2_reg && !cmd_reg && sum_add.sat);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (start) state_next = ST_DIV_H_GO;
            ST_DIV_H_GO:   state_next = ST_DIV_H_WAIT;
            ST_DIV_H_WAIT: if (div_done) state_next = cmd_reg ? ST_DIV_6_GO : ST_GEN_T;
            ST_DIV_6_GO:   state_next = ST_DIV_6_WAIT;
            ST_DIV_6_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (n_reg == INTERVAL_BITS'(1)) ? ST_TAIL0 : ST_GEN_S0;
                end
            end
            ST_GEN_T:      if (i_reg == n_reg) state_next = ST_DRAIN;
            ST_GEN_S0:     state_next = ST_GEN_S1;
            ST_GEN_S1:     state_next = ST_GEN_S2;
            ST_GEN_S2:
            begin
                state_next = (i_reg == (n_reg - 1'b1)) ? ST_TAIL0 : ST_GEN_S0;
            end
            ST_TAIL0:      state_next = ST_TAIL1;
            ST_TAIL1:      state_next = ST_TAIL2;
            ST_TAIL2:      state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (co.valid && co.last)
                begin
                    state_next = cmd_reg ? ST_FIN1 : ST_MUL_WAIT;
                end
            end
            ST_FIN1:       state_next = ST_FIN2;
            ST_FIN2:       state_next = ST_FIN3;
            ST_FIN3:       state_next = ST_MUL_GO;
            ST_MUL_GO:     state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:   if (mul_final) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= mul_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= POLY_DEG; k++)
            begin
                coeff_reg[k] <= 32'd0;
            end
            icount_reg    <= 16'd10;
            pt_valid_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            mq_valid_reg  <= 1'b0;
            mv1_reg       <= 1'b0;
            mv2_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COEFF_X4:       coeff_reg[0] <= cfg_data;
                    REG_COEFF_X3:       coeff_reg[1] <= cfg_data;
                    REG_COEFF_X2:       coeff_reg[2] <= cfg_data;
                    REG_COEFF_X1:       coeff_reg[3] <= cfg_data;
                    REG_COEFF_X0:       coeff_reg[4] <= cfg_data;
                    REG_INTERVAL_COUNT: icount_reg   <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            pt_valid_reg <= (state_reg == ST_GEN_T) || (state_reg == ST_GEN_S1)
                         || (state_reg == ST_GEN_S2) || (state_reg == ST_TAIL0)
                         || (state_reg == ST_TAIL1) || (state_reg == ST_TAIL2);
            if (state_reg == ST_IDLE && start)
            begin
                have_prev_reg <= 1'b0;
            end
            else if (co.valid)
            begin
                have_prev_reg <= 1'b1;
            end
            mq_valid_reg <= (co.valid && !cmd_reg && have_prev_reg)
                         || (state_reg == ST_MUL_GO);
            mv1_reg      <= mq_valid_reg;
            mv2_reg      <= mv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg     <= command;
            a_reg       <= widen_q16(lower_bound);
            b_reg       <= widen_q16(upper_bound);
            n_reg       <= n32[INTERVAL_BITS-1:0];
            sat_acc_reg <= 1'b0;
            sum_reg     <= '0;
            mids_reg    <= '0;
            nodes_reg   <= '0;
        end
        else
        begin
            sat_acc_reg <= sat_acc_reg | sat_new;
            if (mv2_reg && !cmd_reg)
            begin
                sum_reg <= sum_add.val;
            end
            if (co.valid && cmd_reg)
            begin
                case (co.kind)
                    PK_MID:  mids_reg  <= mids_add.val;
                    PK_NODE: nodes_reg <= nodes_add.val;
                    PK_PA:   pa_reg    <= co.acc;
                    PK_PB:   pb_reg    <= co.acc;
                    default: ;
                endcase
            end
        end

        case (state_reg)
            ST_DIV_H_WAIT:
            begin
                if (div_done)
                begin
                    h_reg <= diff[DATA_W-1] ? (~quot_ext + 64'd1) : quot_ext;
                    p_reg <= '0;
                    i_reg <= '0;
                end
            end
            ST_DIV_6_GO:
            begin
                hh_reg <= half_tz(h_reg);
            end
            ST_DIV_6_WAIT:
            begin
                if (div_done)
                begin
                    h6_reg <= h_reg[DATA_W-1] ? (~quot_ext + 64'd1) : quot_ext;
                    p_reg  <= {{(PW-DATA_W){h_reg[DATA_W-1]}}, h_reg};
                    i_reg  <= INTERVAL_BITS'(1);
                end
            end
            ST_GEN_T:
            begin
                pt_x_reg    <= x_add.val;
                pt_sat_reg  <= x_add.sat | p_clip_sat;
                pt_kind_reg <= PK_NODE;
                pt_last_reg <= (i_reg == n_reg);
                p_reg       <= p_reg + {{(PW-DATA_W){h_reg[DATA_W-1]}}, h_reg};
                i_reg       <= i_reg + 1'b1;
            end
            ST_GEN_S0:
            begin
                xh_reg     <= x_add.val;
                xh_sat_reg <= x_add.sat | p_clip_sat;
            end
            ST_GEN_S1:
            begin
                pt_x_reg    <= mid_sub.val;
                pt_sat_reg  <= xh_sat_reg | mid_sub.sat;
                pt_kind_reg <= PK_MID;
                pt_last_reg <= 1'b0;
            end
            ST_GEN_S2:
            begin
                pt_x_reg    <= xh_reg;
                pt_sat_reg  <= xh_sat_reg;
                pt_kind_reg <= PK_NODE;
                pt_last_reg <= 1'b0;
                p_reg       <= p_reg + {{(PW-DATA_W){h_reg[DATA_W-1]}}, h_reg};
                i_reg       <= i_reg + 1'b1;
            end
            ST_TAIL0:
            begin
                pt_x_reg    <= bmid_sub.val;
                pt_sat_reg  <= bmid_sub.sat;
                pt_kind_reg <= PK_MID;
                pt_last_reg <= 1'b0;
            end
            ST_TAIL1:
            begin
                pt_x_reg    <= a_reg;
                pt_sat_reg  <= 1'b0;
                pt_kind_reg <= PK_PA;
                pt_last_reg <= 1'b0;
            end
            ST_TAIL2:
            begin
                pt_x_reg    <= b_reg;
                pt_sat_reg  <= 1'b0;
                pt_kind_reg <= PK_PB;
                pt_last_reg <= 1'b1;
            end
            ST_FIN1: total_reg <= fin1_add.val;
            ST_FIN2: total_reg <= fin2_add.val;
            ST_FIN3: total_reg <= fin3_add.val;
            default: ;
        endcase

        if (co.valid && !cmd_reg)
        begin
            prev_reg <= co.acc;
            if (have_prev_reg)
            begin
                mq_a_reg    <= half_tz(avg_add.val);
                mq_b_reg    <= h_reg;
                mq_last_reg <= co.last;
            end
        end
        if (state_reg == ST_MUL_GO)
        begin
            mq_a_reg    <= h6_reg;
            mq_b_reg    <= total_reg;
            mq_last_reg <= 1'b1;
        end
        ml1_reg <= mq_last_reg;
        ml2_reg <= ml1_reg;

        if (mul_final)
        begin
            integral_reg  <= cmd_reg ? mul_prod : sum_add.val;
            saturated_reg <= sat_acc_reg | sat_new;
        end
    end

    `PINT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
    `PINT_ASSERT_IMPL(a_chain_busy, co.valid, busy, "Horner chain produced a beat while idle")
    `PINT_ASSERT_IMPL(a_div_wait, div_done, (state_reg == ST_DIV_H_WAIT) || (state_reg == ST_DIV_6_WAIT), "divider finished outside a wait state")
    `PINT_ASSERT_IMPL(a_done_idle, done, !busy, "result beat while still busy")

endmodule

// ===== test/pint_checker.sv =====
// Checker for the polynomial integrator: watches the config, command and result ports,
// predicts each integral in Q32.32 and compares every result beat.
// Depends on pint_pkg for the register index codes and the Q32.32 type.
`timescale 1ns / 1ps

module pint_checker
    import pint_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 command,
    input  logic signed [31:0]   lower_bound,
    input  logic signed [31:0]   upper_bound,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 done,
    input  logic signed [63:0]   integral,
    input  logic                 saturated,
    output int                   errors,
    output int                   pending
);

    typedef struct {
        q32_t value;
        bit   sat;
    } integral_t;

    logic [31:0] coef [5];
    logic [15:0] steps;
    bit          sat_seen;
    integral_t   expected_q[$];

    assign pending = expected_q.size();

    function automatic q32_t to_q32(logic [31:0] v);
        return {{16{v[31]}}, v, 16'h0000};
    endfunction

    function automatic q32_t add_q(q32_t a, q32_t b);
        q32_t s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_seen = 1;
            s = a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    function automatic q32_t sub_q(q32_t a, q32_t b);
        q32_t s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            sat_seen = 1;
            s = a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    function automatic q32_t mul_q(q32_t a, q32_t b, int shift);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [127:0] lim;
        bit           neg;
        neg = a[63] ^ b[63];
        ua  = a[63] ? 64'(0) - a : a;
        ub  = b[63] ? 64'(0) - b : b;
        p   = {64'b0, ua} * {64'b0, ub};
        p   = p >> shift;
        lim = 128'h1 << 63;
        if (neg)
        begin
            if (p > lim)
            begin
                sat_seen = 1;
                return Q_MIN;
            end
            return 64'(0) - p[63:0];
        end
        if (p >= lim)
        begin
            sat_seen = 1;
            return Q_MAX;
        end
        return p[63:0];
    endfunction

    function automatic q32_t horner(q32_t x);
        q32_t acc;
        acc = to_q32(coef[0]);
        for (int k = 1; k < 5; k++)
            acc = add_q(mul_q(acc, x, 32), to_q32(coef[k]));
        return acc;
    endfunction

    function automatic integral_t integrate(logic cmd, logic [31:0] lo, logic [31:0] hi);
        integral_t r;
        q32_t      a;
        q32_t      b;
        q32_t      h;
        q32_t      n;
        q32_t      sum;
        q32_t      mids;
        q32_t      nodes;
        q32_t      x;
        q32_t      hh;
        n = (steps == 0) ? 64'sd1 : $signed({48'b0, steps});
        a = to_q32(lo);
        b = to_q32(hi);
        sat_seen = 0;
        h = sub_q(b, a) / n;
        if (!cmd)
        begin
            sum = 0;
            for (longint i = 0; i < n; i++)
                sum = add_q(sum, mul_q(add_q(horner(add_q(a, mul_q(h, i, 0))),
                    horner(add_q(a, mul_q(h, i + 1, 0)))) / 64'sd2, h, 32));
        end
        else
        begin
            hh = h / 64'sd2;
            mids = 0;
            nodes = 0;
            for (longint i = 1; i < n; i++)
            begin
                x = add_q(a, mul_q(h, i, 0));
                mids = add_q(mids, horner(sub_q(x, hh)));
                nodes = add_q(nodes, horner(x));
            end
            mids = add_q(mids, horner(sub_q(b, hh)));
            sum = add_q(horner(a), horner(b));
            sum = add_q(sum, mul_q(nodes, 64'sd2, 0));
            sum = add_q(sum, mul_q(mids, 64'sd4, 0));
            sum = mul_q(h / 64'sd6, sum, 32);
        end
        r.value = sum;
        r.sat = sat_seen;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        integral_t e;
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
                coef[k] <= '0;
            steps <= 16'd10;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result beat", integral, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (integral !== e.value)
                        report_mismatch("integral", integral, e.value);
                    if (saturated !== e.sat)
                        report_mismatch("saturated", saturated, e.sat);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COEFF_X4:       coef[0] <= cfg_data;
                    REG_COEFF_X3:       coef[1] <= cfg_data;
                    REG_COEFF_X2:       coef[2] <= cfg_data;
                    REG_COEFF_X1:       coef[3] <= cfg_data;
                    REG_COEFF_X0:       coef[4] <= cfg_data;
                    REG_INTERVAL_COUNT: steps <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_q.push_back(integrate(command, lower_bound, upper_bound));
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the polynomial integrator testbench: clock, reset, config writes and commands
// with random gaps; pint_checker does the prediction. Depends on pint_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import pint_pkg::*;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    logic                 command = 0;
    logic signed [31:0]   lower_bound = '0;
    logic signed [31:0]   upper_bound = '0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 done;
    logic signed [63:0]   integral;
    logic                 saturated;
    int                   errors;
    int                   pending;
    bit                   no_gaps = 0;

    always #4 clk = ~clk;

    polynomial_integrator u_top (.*);

    pint_checker u_checker (.*);

    function automatic logic [31:0] pick_q16(int span);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    task automatic wait_idle();
        start <= 0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        if (!no_gaps && $urandom_range(0, 99) < 25)
        begin
            cfg_valid <= 0;
            @(posedge clk);
        end
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_all(logic [31:0] c4, logic [31:0] c3, logic [31:0] c2,
                           logic [31:0] c1, logic [31:0] c0, logic [31:0] n);
        wait_idle();
        write_reg(REG_COEFF_X4, c4);
        write_reg(REG_COEFF_X3, c3);
        write_reg(REG_COEFF_X2, c2);
        write_reg(REG_COEFF_X1, c1);
        write_reg(REG_COEFF_X0, c0);
        write_reg(REG_INTERVAL_COUNT, n);
        if ($urandom_range(0, 3) == 0)
            write_reg(cfg_reg_t'($urandom_range(6, 7)), $urandom);
        cfg_valid <= 0;
    endtask

    task automatic integrate(logic cmd, logic [31:0] lo, logic [31:0] hi);
        if (!no_gaps && $urandom_range(0, 99) < 25)
        begin
            start <= 0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        start <= 1;
        command <= cmd;
        lower_bound <= lo;
        upper_bound <= hi;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [31:0] n;
        repeat (4)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        integrate(0, 32'h0001_0000, 32'h0003_0000);
        integrate(1, 32'h0001_0000, 32'h0003_0000);

        set_all(32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000,
                32'hFFFE_0000, 32'hFFFF_0000);
        integrate(0, 32'h0000_0000, 32'h0002_0000);
        integrate(1, 32'h0000_0000, 32'h0002_0000);
        integrate(0, 32'h0002_0000, 32'hFFFE_0000);
        integrate(1, 32'h0002_0000, 32'hFFFE_0000);
        integrate(0, 32'h8000_0000, 32'h7FFF_FFFF);
        integrate(1, 32'h7FFF_FFFF, 32'h8000_0000);

        set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0000_0001);
        integrate(0, 32'hFFFF_0000, 32'h0001_0000);
        integrate(1, 32'hFFFF_0000, 32'h0001_0000);
        integrate(0, 32'h8000_0000, 32'h7FFF_FFFF);
        integrate(1, 32'h0000_0000, 32'h0000_0000);

        set_all(0, 0, 32'h0003_0000, 0, 32'h0000_8000, 32'h0000_0000);
        integrate(0, 32'h0000_0000, 32'h0001_0000);
        integrate(1, 32'h0000_0000, 32'h0001_0000);

        set_all(0, 32'h0000_1000, 0, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_FFFF);
        integrate(0, 32'hFFFF_0000, 32'h0001_0000);
        integrate(1, 32'h0001_0000, 32'hFFFF_0000);

        for (int ph = 0; ph < 40; ph++)
        begin
            no_gaps = (ph >= 10 && ph < 15);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            n[31:16] = $urandom;
            set_all(pick_q16(1 << 17), pick_q16(1 << 17), pick_q16(1 << 18),
                    pick_q16(1 << 18), pick_q16(1 << 19), n);
            repeat (33)
                integrate($urandom_range(0, 1), pick_q16(1 << 19), pick_q16(1 << 19));
        end

        wait_idle();
        repeat (150)
            @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
